// ----- src/gda_pkg.sv -----
// shared types, constants and calendar functions for the date unit
package gda_pkg;

  localparam int unsigned EpochYearDefault = 1970;
  localparam int unsigned MaxYear          = 9999;
  localparam int unsigned DaysPer400Y      = 146097;
  localparam int unsigned OrdWidth         = 23;
  localparam int unsigned MaxOrd           = 3652059; // days before year 10000
  localparam int unsigned MonthSatTotal    = MaxYear * 12; // month total of year 10000

  // reciprocal constants, exact floor division over the operand widths used
  localparam int unsigned Recip100Shift  = 21;  // 14-bit dividend
  localparam int unsigned Recip100       = ((1 << Recip100Shift) + 99) / 100;
  localparam int unsigned Recip12Shift   = 21;  // 17-bit dividend
  localparam int unsigned Recip12        = ((1 << Recip12Shift) + 11) / 12;
  localparam int unsigned Recip366Shift  = 27;  // 18-bit dividend
  localparam int unsigned Recip366       = ((1 << Recip366Shift) + 365) / 366;
  localparam int unsigned Recip400YShift = 40;  // 22-bit dividend
  localparam longint unsigned Recip400Y  =
    ((64'd1 << Recip400YShift) + 64'(DaysPer400Y) - 64'd1) / 64'(DaysPer400Y);

  typedef enum logic [1:0] {
    REQ_VALIDATE = 2'd0,
    REQ_ADD_DAYS = 2'd1,
    REQ_ADD_MON  = 2'd2,
    REQ_EPOCH    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [1:0]  status;
  } date_t;

  // leap year test on a narrow year, century check by reciprocal multiply
  function automatic logic is_leap(input logic [13:0] y);
    logic [28:0] prod;
    logic [13:0] q100;
    logic        cent;
    begin
      prod    = 29'(y) * 29'(Recip100);
      q100    = 14'(prod >> Recip100Shift);
      cent    = (14'(q100 * 14'd100) == y);
      is_leap = (y[1:0] == 2'b00) && (!cent || (q100[1:0] == 2'b00));
    end
  endfunction

  // month length, zero for codes outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [13:0] y);
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                   month_len = 5'd30;
        4'd2:    month_len = is_leap(y) ? 5'd29 : 5'd28;
        default: month_len = 5'd0;
      endcase
    end
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    begin
      unique case (m)
        4'd1:  cum_days = 9'd0;
        4'd2:  cum_days = 9'd31;
        4'd3:  cum_days = 9'd59;
        4'd4:  cum_days = 9'd90;
        4'd5:  cum_days = 9'd120;
        4'd6:  cum_days = 9'd151;
        4'd7:  cum_days = 9'd181;
        4'd8:  cum_days = 9'd212;
        4'd9:  cum_days = 9'd243;
        4'd10: cum_days = 9'd273;
        4'd11: cum_days = 9'd304;
        4'd12: cum_days = 9'd334;
        default: cum_days = 9'd0;
      endcase
    end
  endfunction

  // days from 0001-01-01 to jan 1 of year y
  function automatic logic [OrdWidth-1:0] days_before_year(input logic [13:0] y);
    logic [13:0] p;
    logic [28:0] prod;
    logic [13:0] q100;
    logic [23:0] acc;
    begin
      p    = y - 14'd1;
      prod = 29'(p) * 29'(Recip100);
      q100 = 14'(prod >> Recip100Shift);
      // p / 400 is the century count over four
      acc  = 24'(p) * 24'd365 + 24'(p >> 2) - 24'(q100) + 24'(q100 >> 2);
      days_before_year = OrdWidth'(acc);
    end
  endfunction

endpackage

// ----- src/gda_if.sv -----
// valid/ready channel interfaces for requests and results
interface gda_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  day_in;
  logic [3:0]  month_in;
  logic [13:0] year_in;
  logic [21:0] amount;
  modport source (output valid, req_type, day_in, month_in, year_in, amount, input ready);
  modport sink   (input valid, req_type, day_in, month_in, year_in, amount, output ready);
endinterface

interface gda_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;
  logic [1:0]  status;
  modport source (output valid, day_out, month_out, year_out, status, input ready);
  modport sink   (input valid, day_out, month_out, year_out, status, output ready);
endinterface

// ----- src/gda_front.sv -----
// front stages: validation, ordinal day and month arithmetic
module gda_front #(
  parameter int unsigned EpochYear = gda_pkg::EpochYearDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [1:0]                   req_type_i,
  input  logic [4:0]                   day_i,
  input  logic [3:0]                   month_i,
  input  logic [13:0]                  year_i,
  input  logic [21:0]                  amount_i,
  output logic                         valid_o,
  output logic                         walk_o,   // result comes from ordinal walk
  output logic [gda_pkg::OrdWidth-1:0] ord_o,
  output gda_pkg::date_t               direct_o
);
  localparam int unsigned OW = gda_pkg::OrdWidth;
  localparam logic [OW-1:0] EpochOrd = OW'(gda_pkg::days_before_year(14'(EpochYear)));

  // stage 1 registers
  logic        v1_q;
  logic [1:0]  t1_q;
  logic [4:0]  d1_q;
  logic [3:0]  m1_q;
  logic [13:0] y1_q;
  logic [21:0] a1_q;
  logic        ok1_q;
  logic [OW-1:0] base1_q;
  logic [8:0]  cum1_q;
  logic [4:0]  mlen_d;
  logic        ok_d;

  always_comb begin
    mlen_d = gda_pkg::month_len(month_i, year_i);
    ok_d   = (month_i >= 4'd1) && (month_i <= 4'd12) && (year_i >= 14'd1) &&
             (year_i <= 14'(gda_pkg::MaxYear)) && (day_i >= 5'd1) && (day_i <= mlen_d);
  end

  // stage 1: validity, year base and month offset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= req_type_i;
      d1_q    <= day_i;
      m1_q    <= month_i;
      y1_q    <= year_i;
      a1_q    <= amount_i;
      ok1_q   <= ok_d;
      base1_q <= gda_pkg::days_before_year(year_i);
      cum1_q  <= gda_pkg::cum_days(month_i) +
                 9'(((month_i > 4'd2) && gda_pkg::is_leap(year_i)) ? 1 : 0);
    end
  end

  // stage 2: ordinal sum and month total
  logic [18:0] tot_d;
  logic [OW-1:0] ord_d;
  gda_pkg::date_t dir_d;
  logic        walk_d;

  always_comb begin
    tot_d = 19'(y1_q - 14'd1) * 19'd12 + 19'(m1_q - 4'd1);
    ord_d = base1_q + OW'(cum1_q) + OW'(d1_q - 5'd1) + OW'(a1_q);
    walk_d = 1'b0;
    dir_d  = '0;
    unique case (gda_pkg::req_e'(t1_q))
      gda_pkg::REQ_EPOCH: begin
        walk_d = 1'b1;
        ord_d  = EpochOrd + OW'(a1_q);
      end
      gda_pkg::REQ_VALIDATE: begin
        dir_d = '{day: d1_q, month: m1_q, year: y1_q, status: gda_pkg::ST_OK};
      end
      gda_pkg::REQ_ADD_DAYS: begin
        walk_d = 1'b1;
      end
      default: ;
    endcase
    if (!ok1_q && (gda_pkg::req_e'(t1_q) != gda_pkg::REQ_EPOCH)) begin
      walk_d = 1'b0;
      dir_d  = '{day: 5'd0, month: 4'd0, year: 14'd0, status: gda_pkg::ST_INVALID};
    end
  end

  // month total carried into stage 3 for the split by 12
  logic        v2_q;
  logic        walk2_q;
  logic        mon2_q;
  logic [22:0] tot2_q;
  logic [4:0]  d2_q;
  logic [OW-1:0] ord2_q;
  gda_pkg::date_t dir2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      walk2_q <= walk_d;
      mon2_q  <= ok1_q && (gda_pkg::req_e'(t1_q) == gda_pkg::REQ_ADD_MON);
      tot2_q  <= 23'(tot_d) + 23'(a1_q);
      d2_q    <= d1_q;
      ord2_q  <= ord_d;
      dir2_q  <= dir_d;
    end
  end

  // stage 3: split month total into year and month, only below the overflow total
  logic [34:0] qprod;
  logic [13:0] q12;
  logic [3:0]  r12;
  logic        msat_d;

  always_comb begin
    msat_d = tot2_q >= 23'(gda_pkg::MonthSatTotal);
    qprod  = 35'(tot2_q[16:0]) * 35'(gda_pkg::Recip12);
    q12    = 14'(qprod >> gda_pkg::Recip12Shift);
    r12    = 4'(tot2_q[16:0] - 17'(q12) * 17'd12);
  end

  logic        v3_q;
  logic        walk3_q;
  logic        mon3_q;
  logic        msat3_q;
  logic [13:0] ny3_q;
  logic [3:0]  nm3_q;
  logic [4:0]  d3_q;
  logic [OW-1:0] ord3_q;
  gda_pkg::date_t dir3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      walk3_q <= walk2_q;
      mon3_q  <= mon2_q;
      msat3_q <= msat_d;
      ny3_q   <= q12 + 14'd1;
      nm3_q   <= r12 + 4'd1;
      d3_q    <= d2_q;
      ord3_q  <= ord2_q;
      dir3_q  <= dir2_q;
    end
  end

  // stage 4: month result with day clamp or overflow
  logic [4:0]  lim4_d;
  gda_pkg::date_t dir4_d;

  always_comb begin
    lim4_d = gda_pkg::month_len(nm3_q, ny3_q);
    dir4_d = dir3_q;
    if (mon3_q) begin
      if (msat3_q) begin
        dir4_d = '{day: 5'd31, month: 4'd12, year: 14'(gda_pkg::MaxYear),
                   status: gda_pkg::ST_OVERFLOW};
      end else begin
        dir4_d = '{day: (d3_q > lim4_d) ? lim4_d : d3_q, month: nm3_q, year: ny3_q,
                   status: gda_pkg::ST_OK};
      end
    end
  end

  logic        v4_q;
  logic        walk4_q;
  logic [OW-1:0] ord4_q;
  gda_pkg::date_t dir4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      walk4_q <= walk3_q;
      ord4_q  <= ord3_q;
      dir4_q  <= dir4_d;
    end
  end

  assign valid_o  = v4_q;
  assign walk_o   = walk4_q;
  assign ord_o    = ord4_q;
  assign direct_o = dir4_q;
endmodule

// ----- src/gda_back.sv -----
// back stages: ordinal day to date
module gda_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         walk_i,
  input  logic [gda_pkg::OrdWidth-1:0] ord_i,
  input  gda_pkg::date_t               direct_i,
  output logic                         valid_o,
  output gda_pkg::date_t               date_o
);

  // leap test for year index e inside a 400-year cycle starting at year 1 mod 400
  function automatic logic cyc_leap(input logic [8:0] e);
    logic [9:0] n;
    begin
      n = 10'(e) + 10'd1;
      cyc_leap = (n[1:0] == 2'b00) &&
                 (((n != 10'd100) && (n != 10'd200) && (n != 10'd300)) || (n == 10'd400));
    end
  endfunction

  // stage 5: 400-year cycle count by reciprocal multiply, saturation check
  logic [44:0] cprod;
  logic [4:0]  cyc_d;
  always_comb begin
    cprod = 45'(ord_i[21:0]) * 45'(gda_pkg::Recip400Y);
    cyc_d = 5'(cprod >> gda_pkg::Recip400YShift);
  end

  logic        v5_q, w5_q, sat5_q;
  logic [4:0]  cyc5_q;
  logic [21:0] ord5_q;
  gda_pkg::date_t dir5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en_i) v5_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w5_q   <= walk_i;
      sat5_q <= ord_i >= gda_pkg::OrdWidth'(gda_pkg::MaxOrd);
      cyc5_q <= cyc_d;
      ord5_q <= ord_i[21:0];
      dir5_q <= direct_i;
    end
  end

  // stage 6: day within the cycle and first year of the cycle
  logic        v6_q, w6_q, sat6_q;
  logic [13:0] yb6_q;
  logic [17:0] r6_q;
  gda_pkg::date_t dir6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en_i) v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w6_q   <= w5_q;
      sat6_q <= sat5_q;
      yb6_q  <= 14'(cyc5_q) * 14'd400 + 14'd1;
      r6_q   <= 18'(ord5_q - 22'(cyc5_q) * 22'(gda_pkg::DaysPer400Y));
      dir6_q <= dir5_q;
    end
  end

  // stage 7: year estimate as day in cycle over 366, never above the true year
  logic [36:0] eprod;
  logic [8:0]  yest;
  always_comb begin
    eprod = 37'(r6_q) * 37'(gda_pkg::Recip366);
    yest  = 9'(eprod >> gda_pkg::Recip366Shift);
  end

  logic        v7_q, w7_q, sat7_q;
  logic [13:0] yb7_q;
  logic [17:0] r7_q;
  logic [8:0]  e7_q;
  gda_pkg::date_t dir7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en_i) v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w7_q   <= w6_q;
      sat7_q <= sat6_q;
      yb7_q  <= yb6_q;
      r7_q   <= r6_q;
      e7_q   <= yest;
      dir7_q <= dir6_q;
    end
  end

  // stage 8: day of year from estimate, one correction
  logic [1:0]  c100;
  logic [17:0] dby, doy_raw, doy, ylen;
  logic [8:0]  e8;
  always_comb begin
    c100 = (e7_q >= 9'd300) ? 2'd3 : (e7_q >= 9'd200) ? 2'd2 :
           (e7_q >= 9'd100) ? 2'd1 : 2'd0;
    dby     = 18'(e7_q) * 18'd365 + 18'(e7_q >> 2) - 18'(c100);
    doy_raw = r7_q - dby;
    ylen    = cyc_leap(e7_q) ? 18'd366 : 18'd365;
    doy     = doy_raw;
    e8      = e7_q;
    if (doy_raw >= ylen) begin
      doy = doy_raw - ylen;
      e8  = e7_q + 9'd1;
    end
  end

  logic        v8_q, w8_q, sat8_q;
  logic [13:0] y8_q;
  logic [8:0]  e8_q;
  logic [8:0]  doy8_q;
  gda_pkg::date_t dir8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else if (en_i) v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w8_q   <= w7_q;
      sat8_q <= sat7_q;
      y8_q   <= yb7_q + 14'(e8);
      e8_q   <= e8;
      doy8_q <= 9'(doy);
      dir8_q <= dir7_q;
    end
  end

  // stage 9: month lookup over eleven independent compares
  logic [3:0] mo;
  logic [8:0] start;
  logic       lp;
  gda_pkg::date_t res_d;
  always_comb begin
    lp = cyc_leap(e8_q);
    mo = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy8_q >= gda_pkg::cum_days(4'(k)) + 9'(((k > 2) && lp) ? 1 : 0)) mo = 4'(k);
    end
    start = gda_pkg::cum_days(mo) + 9'(((mo > 4'd2) && lp) ? 1 : 0);
    if (!w8_q) begin
      res_d = dir8_q;
    end else if (sat8_q) begin
      res_d = '{day: 5'd31, month: 4'd12, year: 14'(gda_pkg::MaxYear),
                status: gda_pkg::ST_OVERFLOW};
    end else begin
      res_d = '{day: 5'(doy8_q - start) + 5'd1, month: mo, year: y8_q,
                status: gda_pkg::ST_OK};
    end
  end

  logic v9_q;
  gda_pkg::date_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else if (en_i) v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign valid_o = v9_q;
  assign date_o  = res_q;
endmodule

// ----- src/gregorian_date_arithmetic.sv -----
// gregorian date unit: validate, add days, add months, epoch day to date
// pipeline: nine register stages between a request beat and its result beat
// throughput: one request beat per cycle, whole pipe stalls when result is held
// reset: asynchronous active low clears all stage valid bits, no clearing pass
module gregorian_date_arithmetic #(
  parameter int unsigned EpochYear = gda_pkg::EpochYearDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gda_req_if.sink    req,
  gda_res_if.source  res
);
  logic en;
  logic fv;
  logic fw;
  logic [gda_pkg::OrdWidth-1:0] ford;
  gda_pkg::date_t fdir;
  gda_pkg::date_t bdate;

  // pipe advances unless the output holds an untaken result
  assign en        = !res.valid || res.ready;
  assign req.ready = en;

  gda_front #(.EpochYear(EpochYear)) u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(req.valid),
    .req_type_i(req.req_type), .day_i(req.day_in), .month_i(req.month_in),
    .year_i(req.year_in), .amount_i(req.amount),
    .valid_o(fv), .walk_o(fw), .ord_o(ford), .direct_o(fdir)
  );

  gda_back u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .walk_i(fw), .ord_i(ford),
    .direct_i(fdir), .valid_o(res.valid), .date_o(bdate)
  );

  assign res.day_out   = bdate.day;
  assign res.month_out = bdate.month;
  assign res.year_out  = bdate.year;
  assign res.status    = bdate.status;
endmodule
